@@ design/imu_frame_parser_unit_assert.svh @@
// ----------------------------------------------------------------------------
// imu_frame_parser_unit_assert.svh
// Assertion macros shared by the frame parser's checker.
// ----------------------------------------------------------------------------
`ifndef IMU_FRAME_PARSER_UNIT_ASSERT_SVH
`define IMU_FRAME_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define IMUFP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define IMUFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/imufp_pkg.sv @@
// ----------------------------------------------------------------------------
// imufp_pkg
// Types, constants and the scaling function of the IMU frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package imufp_pkg;

	// Frame layout
	localparam int FRAME_BYTES    = 11;
	localparam int POS_W          = 4;
	localparam int FIRST_DATA_POS = 2;
	localparam int PAYLOAD_BYTES  = 6;
	localparam int PAYLOAD_IDX_W  = 3;
	localparam int SCALED_W       = 25;
	localparam int PRODUCT_W      = 27;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER     = 2'd0,
		REG_GYRO_TYPE  = 2'd1,
		REG_ANGLE_TYPE = 2'd2
	} cfg_reg_t;

	// Reset values of the configuration registers
	localparam logic [7:0] HEADER_RST     = 8'h55;
	localparam logic [7:0] GYRO_TYPE_RST  = 8'h52;
	localparam logic [7:0] ANGLE_TYPE_RST = 8'h53;

	// Frame kinds
	localparam logic KIND_GYRO  = 1'b0;
	localparam logic KIND_ANGLE = 1'b1;

	// Scale factors, units of 2^-13 degree (per second for gyro)
	localparam logic signed [PRODUCT_W-1:0] GYRO_SCALE  = 27'sd500;
	localparam logic signed [PRODUCT_W-1:0] ANGLE_SCALE = 27'sd45;

	// Parser phases
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_TYPE   = 2'd1,
		PH_DATA   = 2'd2
	} phase_t;

	// One checked frame, as handed from parser to scaler
	typedef struct packed {
		logic               kind;
		logic signed [15:0] raw_x;
		logic signed [15:0] raw_y;
		logic signed [15:0] raw_z;
	} frame_t;

	// raw * 500 (gyro) or raw * 45 (angle), kept to the output width
	function automatic logic signed [SCALED_W-1:0] scale_word(
		input logic signed [15:0] raw,
		input logic               kind
	);
		logic signed [PRODUCT_W-1:0] prod;
		prod = PRODUCT_W'(raw) * ((kind == KIND_ANGLE) ? ANGLE_SCALE : GYRO_SCALE);
		return prod[SCALED_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ design/imu_frame_parser_unit.sv @@
// A frame's result passes the checked frame register, then the output register.
// Throughput: one byte per cycle, held only while both result stages are full
// and out_stall is high; state and checksum update in the cycle a byte lands.
// Reset: arst_n clears the parser to waiting for a header, the checksum to zero
// and both result stages to empty; registers return to 0x55, 0x52 and 0x53.
// ----------------------------------------------------------------------------
// imu_frame_parser_unit
// Serial sensor frame parser: header, type, eight data bytes (six kept), checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_frame_parser_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [imufp_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  wire logic [7:0]                            cfg_wdata,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [7:0]                            rx_byte,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic                                       frame_kind,
	output logic signed [15:0]                         raw_x,
	output logic signed [15:0]                         raw_y,
	output logic signed [15:0]                         raw_z,
	output logic signed [imufp_pkg::SCALED_W-1:0]      scaled_x,
	output logic signed [imufp_pkg::SCALED_W-1:0]      scaled_y,
	output logic signed [imufp_pkg::SCALED_W-1:0]      scaled_z
);

	logic              adv;
	logic              res_valid_s1;
	imufp_pkg::frame_t res_s1;

	// Frame tracking and checksum
	imufp_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.adv          (adv),
		.res_valid_s1 (res_valid_s1),
		.res_s1       (res_s1)
	);

	// Scaling and output register
	imufp_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid_s1 (res_valid_s1),
		.res_s1       (res_s1),
		.adv          (adv),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_kind   (frame_kind),
		.raw_x        (raw_x),
		.raw_y        (raw_y),
		.raw_z        (raw_z),
		.scaled_x     (scaled_x),
		.scaled_y     (scaled_y),
		.scaled_z     (scaled_z)
	);

endmodule

`default_nettype wire

@@ design/imufp_parser.sv @@
// ----------------------------------------------------------------------------
// imufp_parser
// Byte-wise frame tracker with running checksum; registers checked frames.
// ----------------------------------------------------------------------------
`default_nettype none

module imufp_parser (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [imufp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [7:0]                      cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [7:0]                      rx_byte,
	input  wire logic                            adv,
	output logic                                 res_valid_s1,
	output imufp_pkg::frame_t                    res_s1
);

	logic [7:0] header_q;
	logic [7:0] gyro_type_q;
	logic [7:0] angle_type_q;

	imufp_pkg::phase_t                 phase_q, phase_d;
	logic [imufp_pkg::POS_W-1:0]       pos_q, pos_d;
	logic                              kind_q, kind_d;
	logic [7:0]                        sum_q, sum_d;
	logic [7:0]                        payload_q [imufp_pkg::PAYLOAD_BYTES];

	logic                                  acc;
	logic                                  hit;
	logic                                  pl_we;
	logic [imufp_pkg::PAYLOAD_IDX_W-1:0]   pl_idx;
	logic [imufp_pkg::POS_W-1:0]           pos_off;

	// Handshake: hold off while a checked frame waits downstream
	assign in_stall = res_valid_s1 && !adv;
	assign acc      = in_valid && !in_stall;
	assign pos_off  = pos_q - imufp_pkg::POS_W'(imufp_pkg::FIRST_DATA_POS);
	assign pl_idx   = pos_off[imufp_pkg::PAYLOAD_IDX_W-1:0];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q     <= imufp_pkg::HEADER_RST;
			gyro_type_q  <= imufp_pkg::GYRO_TYPE_RST;
			angle_type_q <= imufp_pkg::ANGLE_TYPE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				imufp_pkg::REG_HEADER:     header_q     <= cfg_wdata;
				imufp_pkg::REG_GYRO_TYPE:  gyro_type_q  <= cfg_wdata;
				imufp_pkg::REG_ANGLE_TYPE: angle_type_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Next state for one accepted beat
	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		kind_d  = kind_q;
		sum_d   = sum_q;
		hit     = 1'b0;
		pl_we   = 1'b0;
		case (phase_q)
			imufp_pkg::PH_HEADER: begin
				if (rx_byte == header_q) begin
					sum_d   = rx_byte;
					phase_d = imufp_pkg::PH_TYPE;
				end
			end
			imufp_pkg::PH_TYPE: begin
				if (rx_byte == gyro_type_q || rx_byte == angle_type_q) begin
					kind_d  = (rx_byte == gyro_type_q) ? imufp_pkg::KIND_GYRO
					                                   : imufp_pkg::KIND_ANGLE;
					sum_d   = sum_q + rx_byte;
					pos_d   = imufp_pkg::POS_W'(imufp_pkg::FIRST_DATA_POS);
					phase_d = imufp_pkg::PH_DATA;
				end else if (rx_byte == header_q) begin
					// repeated header: restart the sum, keep waiting for type
					sum_d = rx_byte;
				end else begin
					phase_d = imufp_pkg::PH_HEADER;
				end
			end
			imufp_pkg::PH_DATA: begin
				if (pos_q < imufp_pkg::POS_W'(imufp_pkg::FRAME_BYTES - 1)) begin
					pl_we = (pos_off < imufp_pkg::POS_W'(imufp_pkg::PAYLOAD_BYTES));
					sum_d = sum_q + rx_byte;
					pos_d = pos_q + 1'b1;
				end else begin
					// check byte
					hit     = (rx_byte == sum_q);
					phase_d = imufp_pkg::PH_HEADER;
					pos_d   = '0;
				end
			end
			default: phase_d = imufp_pkg::PH_HEADER;
		endcase
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= imufp_pkg::PH_HEADER;
			pos_q   <= '0;
			kind_q  <= 1'b0;
			sum_q   <= '0;
		end else if (acc) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			kind_q  <= kind_d;
			sum_q   <= sum_d;
		end
	end

	// Payload bytes 2..7, no reset
	always_ff @(posedge clk) begin
		if (acc && pl_we) begin
			payload_q[pl_idx] <= rx_byte;
		end
	end

	// Checked frame register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else if (!res_valid_s1 || adv) begin
			res_valid_s1 <= acc && hit;
		end
	end

	always_ff @(posedge clk) begin
		if ((!res_valid_s1 || adv) && acc && hit) begin
			res_s1.kind  <= kind_q;
			res_s1.raw_x <= {payload_q[1], payload_q[0]};
			res_s1.raw_y <= {payload_q[3], payload_q[2]};
			res_s1.raw_z <= {payload_q[5], payload_q[4]};
		end
	end

endmodule

`default_nettype wire

@@ design/imufp_scale.sv @@
// ----------------------------------------------------------------------------
// imufp_scale
// Scales the three payload words and holds the output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module imufp_scale (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  res_valid_s1,
	input  wire imufp_pkg::frame_t                     res_s1,
	output logic                                       adv,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic                                       frame_kind,
	output logic signed [15:0]                         raw_x,
	output logic signed [15:0]                         raw_y,
	output logic signed [15:0]                         raw_z,
	output logic signed [imufp_pkg::SCALED_W-1:0]      scaled_x,
	output logic signed [imufp_pkg::SCALED_W-1:0]      scaled_y,
	output logic signed [imufp_pkg::SCALED_W-1:0]      scaled_z
);

	imufp_pkg::frame_t                    res_s2;
	logic signed [imufp_pkg::SCALED_W-1:0] sx_s2, sy_s2, sz_s2;
	logic                                 valid_s2;

	// Output register moves when empty or taken
	assign adv = !valid_s2 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= res_valid_s1;
		end
	end

	// One small constant multiply per word
	always_ff @(posedge clk) begin
		if (adv && res_valid_s1) begin
			res_s2 <= res_s1;
			sx_s2  <= imufp_pkg::scale_word(res_s1.raw_x, res_s1.kind);
			sy_s2  <= imufp_pkg::scale_word(res_s1.raw_y, res_s1.kind);
			sz_s2  <= imufp_pkg::scale_word(res_s1.raw_z, res_s1.kind);
		end
	end

	assign out_valid  = valid_s2;
	assign frame_kind = res_s2.kind;
	assign raw_x      = res_s2.raw_x;
	assign raw_y      = res_s2.raw_y;
	assign raw_z      = res_s2.raw_z;
	assign scaled_x   = sx_s2;
	assign scaled_y   = sy_s2;
	assign scaled_z   = sz_s2;

endmodule

`default_nettype wire

@@ design/imufp_checker.sv @@
// ----------------------------------------------------------------------------
// imufp_checker
// Port-level checks on the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "imu_frame_parser_unit_assert.svh"

module imufp_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  in_stall,
	input wire logic                                  out_valid,
	input wire logic                                  out_stall,
	input wire logic                                  frame_kind,
	input wire logic signed [15:0]                    raw_x,
	input wire logic signed [15:0]                    raw_y,
	input wire logic signed [15:0]                    raw_z,
	input wire logic signed [imufp_pkg::SCALED_W-1:0] scaled_x,
	input wire logic signed [imufp_pkg::SCALED_W-1:0] scaled_y,
	input wire logic signed [imufp_pkg::SCALED_W-1:0] scaled_z
);

	// A stalled result beat stays
	`IMUFP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped")

	// Input is never held off while the output side takes beats
	`IMUFP_ASSERT_NOW(a_no_stall, !out_stall, !in_stall, "input stalled with output free")

	// Gyro scaling matches the raw word
	`IMUFP_ASSERT_NOW(a_gyro_scale, out_valid && frame_kind == imufp_pkg::KIND_GYRO, scaled_x == raw_x * 25'sd500 && scaled_z == raw_z * 25'sd500, "gyro scale mismatch")

	// Angle scaling matches the raw word
	`IMUFP_ASSERT_NOW(a_angle_scale, out_valid && frame_kind == imufp_pkg::KIND_ANGLE, scaled_y == raw_y * 25'sd45 && scaled_z == raw_z * 25'sd45, "angle scale mismatch")

endmodule

bind imu_frame_parser_unit imufp_checker u_imufp_checker (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the IMU frame parser byte stream against a local frame decoder:
// directed frames at the word extremes, overlapping type and header codes,
// kind latching across a register change, then long random traffic with
// broken frames, noise and bursty idling on both sides.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int RANDOM_ITEMS = 900;
	localparam int TRAFFIC_PHASES = 6;
	localparam int SETTLE_CYCLES = 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int GYRO_MULT = 500;
	localparam int ANGLE_MULT = 45;

	// One decoded frame as the block should report it
	typedef struct packed {
		logic               kind;
		logic signed [15:0] raw_x;
		logic signed [15:0] raw_y;
		logic signed [15:0] raw_z;
		logic signed [24:0] scl_x;
		logic signed [24:0] scl_y;
		logic signed [24:0] scl_z;
	} frame_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	imufp_pkg::cfg_reg_t   cfg_idx = imufp_pkg::REG_HEADER;
	logic [7:0]            cfg_wdata = 8'h00;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            rx_byte = 8'h00;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  frame_kind;
	logic signed [15:0]    raw_x, raw_y, raw_z;
	logic signed [imufp_pkg::SCALED_W-1:0] scaled_x, scaled_y, scaled_z;

	imu_frame_parser_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_kind (frame_kind),
		.raw_x      (raw_x),
		.raw_y      (raw_y),
		.raw_z      (raw_z),
		.scaled_x   (scaled_x),
		.scaled_y   (scaled_y),
		.scaled_z   (scaled_z)
	);

	always #4 clk = ~clk;

	// Register copies and parser state of the local decoder
	logic [7:0]          hdr_reg = imufp_pkg::HEADER_RST;
	logic [7:0]          gyro_reg = imufp_pkg::GYRO_TYPE_RST;
	logic [7:0]          angle_reg = imufp_pkg::ANGLE_TYPE_RST;
	imufp_pkg::phase_t   hunt_phase = imufp_pkg::PH_HEADER;
	logic [3:0]          byte_pos = 4'd0;
	logic                kind_seen = imufp_pkg::KIND_GYRO;
	logic [7:0]          byte_sum = 8'h00;
	logic [7:0]          payload [imufp_pkg::PAYLOAD_BYTES];

	frame_result_t frames_due [$];
	int unsigned   mismatches = 0;
	int unsigned   bytes_sent = 0;
	int unsigned   idle_cycles = 0;
	int unsigned   stall_left = 0;
	int unsigned   gap_pct = 15;
	int unsigned   stall_pct = 15;
	bit            calm = 1'b0;

	// Build the expected result from the latched kind and payload
	function automatic frame_result_t decode_frame();
		frame_result_t r;
		int            mult;
		int            prod;
		mult = (kind_seen == imufp_pkg::KIND_ANGLE) ? ANGLE_MULT : GYRO_MULT;
		r.kind = kind_seen;
		r.raw_x = {payload[1], payload[0]};
		r.raw_y = {payload[3], payload[2]};
		r.raw_z = {payload[5], payload[4]};
		prod = int'(r.raw_x) * mult;
		r.scl_x = prod[24:0];
		prod = int'(r.raw_y) * mult;
		r.scl_y = prod[24:0];
		prod = int'(r.raw_z) * mult;
		r.scl_z = prod[24:0];
		return r;
	endfunction

	// Advance the decoder by one accepted byte
	function automatic void parse_byte(input logic [7:0] b);
		case (hunt_phase)
			imufp_pkg::PH_HEADER: begin
				if (b == hdr_reg) begin
					byte_sum = b;
					hunt_phase = imufp_pkg::PH_TYPE;
				end
			end
			imufp_pkg::PH_TYPE: begin
				// gyro wins over angle, both win over a repeated header
				if (b == gyro_reg || b == angle_reg) begin
					kind_seen = (b == gyro_reg) ? imufp_pkg::KIND_GYRO
					                            : imufp_pkg::KIND_ANGLE;
					byte_sum = byte_sum + b;
					byte_pos = 4'(imufp_pkg::FIRST_DATA_POS);
					hunt_phase = imufp_pkg::PH_DATA;
				end else if (b == hdr_reg) begin
					byte_sum = b;
				end else begin
					hunt_phase = imufp_pkg::PH_HEADER;
				end
			end
			imufp_pkg::PH_DATA: begin
				if (byte_pos < 4'(imufp_pkg::FRAME_BYTES - 1)) begin
					if (byte_pos >= 4'(imufp_pkg::FIRST_DATA_POS) &&
						byte_pos < 4'(imufp_pkg::FIRST_DATA_POS + imufp_pkg::PAYLOAD_BYTES))
						payload[3'(byte_pos - 4'(imufp_pkg::FIRST_DATA_POS))] = b;
					byte_sum = byte_sum + b;
					byte_pos = byte_pos + 4'd1;
				end else begin
					hunt_phase = imufp_pkg::PH_HEADER;
					byte_pos = 4'd0;
					if (b == byte_sum)
						frames_due.push_back(decode_frame());
				end
			end
			default: hunt_phase = imufp_pkg::PH_HEADER;
		endcase
	endfunction

	function automatic void note_fail(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endfunction

	// Output side: random stall bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(0, 9);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Sample beats on the falling edge ahead of the edge that takes them
	always @(negedge clk) begin : result_watch
		frame_result_t got;
		frame_result_t want;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("stalled for %0d cycles with %0d results owed",
						idle_cycles, frames_due.size());
					$display("SCOREBOARD MISMATCH");
					$finish;
				end
			end
			if (out_valid && !out_stall) begin
				got = '{frame_kind, raw_x, raw_y, raw_z, scaled_x, scaled_y, scaled_z};
				if (frames_due.size() == 0) begin
					note_fail($sformatf("unexpected frame: kind=%0d raw=%0d/%0d/%0d",
						got.kind, got.raw_x, got.raw_y, got.raw_z));
				end else begin
					want = frames_due.pop_front();
					if (got.kind !== want.kind || got.raw_x !== want.raw_x ||
						got.raw_y !== want.raw_y || got.raw_z !== want.raw_z ||
						got.scl_x !== want.scl_x || got.scl_y !== want.scl_y ||
						got.scl_z !== want.scl_z)
						note_fail($sformatf(
							"frame wrong: exp k%0d %0d/%0d/%0d %0d/%0d/%0d got k%0d %0d/%0d/%0d %0d/%0d/%0d",
							want.kind, want.raw_x, want.raw_y, want.raw_z,
							want.scl_x, want.scl_y, want.scl_z,
							got.kind, got.raw_x, got.raw_y, got.raw_z,
							got.scl_x, got.scl_y, got.scl_z));
				end
			end
		end
	end

	// Send one byte; returns at the edge that takes it, valid left high
	task automatic send_byte(input logic [7:0] b);
		bit taken;
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do begin
			@(negedge clk);
			taken = !in_stall;
			if (taken)
				parse_byte(b);
			@(posedge clk);
		end while (!taken);
		bytes_sent++;
	endtask

	// Drop valid, let every owed frame arrive, then let the pipe settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] hdr, input logic [7:0] gyro,
		input logic [7:0] angle);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_idx <= imufp_pkg::REG_HEADER;
		cfg_wdata <= hdr;
		@(posedge clk);
		hdr_reg = hdr;
		cfg_idx <= imufp_pkg::REG_GYRO_TYPE;
		cfg_wdata <= gyro;
		@(posedge clk);
		gyro_reg = gyro;
		cfg_idx <= imufp_pkg::REG_ANGLE_TYPE;
		cfg_wdata <= angle;
		@(posedge clk);
		angle_reg = angle;
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_reg();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Whole frame under the current codes, check byte right or corrupted
	task automatic send_frame(input bit as_angle, input bit good_sum,
		input logic [15:0] wx, input logic [15:0] wy, input logic [15:0] wz);
		logic [7:0] fb [imufp_pkg::FRAME_BYTES];
		logic [7:0] acc;
		fb[0] = hdr_reg;
		fb[1] = as_angle ? angle_reg : gyro_reg;
		{fb[3], fb[2]} = wx;
		{fb[5], fb[4]} = wy;
		{fb[7], fb[6]} = wz;
		fb[8] = 8'($urandom);
		fb[9] = 8'($urandom);
		acc = 8'h00;
		for (int i = 0; i < imufp_pkg::FRAME_BYTES - 1; i++)
			acc = acc + fb[i];
		fb[imufp_pkg::FRAME_BYTES-1] = good_sum ? acc : acc ^ 8'($urandom_range(1, 255));
		for (int i = 0; i < imufp_pkg::FRAME_BYTES; i++)
			send_byte(fb[i]);
	endtask

	// Default codes: stray type byte, repeated header, word extremes, bad check
	task automatic test_directed_frames();
		send_byte(imufp_pkg::HEADER_RST);
		send_byte(8'h00);
		send_byte(imufp_pkg::HEADER_RST);
		send_frame(1'b0, 1'b1, 16'h8000, 16'h7FFF, 16'h0000);
		send_frame(1'b1, 1'b1, 16'hFFFF, 16'h0001, 16'h7FFF);
		send_frame(1'b1, 1'b0, 16'h8000, 16'h8000, 16'hFFFF);
	endtask

	// Codes that collide: gyro over angle, angle over a repeated header
	task automatic test_register_overlap();
		set_config(8'h00, 8'hFF, 8'hFF);
		repeat (6) send_frame(1'($urandom), 1'b1, pick_word(), pick_word(), pick_word());
		set_config(8'hFF, 8'h00, 8'hFF);
		repeat (6) send_frame(1'($urandom), 1'b1, pick_word(), pick_word(), pick_word());
		set_config(8'hA5, 8'hA5, 8'hA5);
		repeat (6) send_frame(1'($urandom), 1'b1, pick_word(), pick_word(), pick_word());
	endtask

	// Kind is fixed by the type byte even if the codes swap mid-frame
	task automatic test_kind_latch();
		logic [7:0] body [imufp_pkg::FRAME_BYTES-3];
		logic [7:0] acc;
		for (int pass = 0; pass < 2; pass++) begin
			set_config(imufp_pkg::HEADER_RST, imufp_pkg::GYRO_TYPE_RST,
				imufp_pkg::ANGLE_TYPE_RST);
			acc = imufp_pkg::HEADER_RST +
				(pass == 0 ? imufp_pkg::GYRO_TYPE_RST : imufp_pkg::ANGLE_TYPE_RST);
			send_byte(imufp_pkg::HEADER_RST);
			send_byte(pass == 0 ? imufp_pkg::GYRO_TYPE_RST : imufp_pkg::ANGLE_TYPE_RST);
			set_config(imufp_pkg::HEADER_RST, imufp_pkg::ANGLE_TYPE_RST,
				imufp_pkg::GYRO_TYPE_RST);
			for (int i = 0; i < imufp_pkg::FRAME_BYTES - 3; i++) begin
				body[i] = 8'($urandom);
				acc = acc + body[i];
			end
			for (int i = 0; i < imufp_pkg::FRAME_BYTES - 3; i++)
				send_byte(body[i]);
			send_byte(acc);
		end
	endtask

	// One random slice of traffic: mostly good frames, some damage
	task automatic traffic_unit();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 66) begin
			send_frame(1'($urandom), 1'b1, pick_word(), pick_word(), pick_word());
		end else if (r < 76) begin
			send_frame(1'($urandom), 1'b0, pick_word(), pick_word(), pick_word());
		end else if (r < 83) begin
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
		end else if (r < 90) begin
			repeat ($urandom_range(1, 3)) send_byte(hdr_reg);
			send_frame(1'($urandom), 1'b1, pick_word(), pick_word(), pick_word());
		end else if (r < 95) begin
			send_byte(hdr_reg);
			send_byte(8'($urandom));
		end else begin
			// truncated frame; the next one gets swallowed as its tail
			send_byte(hdr_reg);
			send_byte($urandom_range(0, 1) ? angle_reg : gyro_reg);
			repeat ($urandom_range(0, 7)) send_byte(8'($urandom));
		end
	endtask

	// Random traffic across several code settings; last phase runs flat out
	task automatic test_random_traffic();
		int unsigned start;
		int unsigned phase_end;
		start = bytes_sent;
		for (int p = 0; p < TRAFFIC_PHASES; p++) begin
			if (p == 0)
				set_config(imufp_pkg::HEADER_RST, imufp_pkg::GYRO_TYPE_RST,
					imufp_pkg::ANGLE_TYPE_RST);
			else
				set_config(pick_reg(), pick_reg(), pick_reg());
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 12;
				default: gap_pct = 40;
			endcase
			case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 12;
				default: stall_pct = 40;
			endcase
			calm = (p == TRAFFIC_PHASES - 1);
			phase_end = start + (RANDOM_ITEMS * (p + 1)) / TRAFFIC_PHASES;
			while (bytes_sent < phase_end)
				traffic_unit();
		end
	endtask

	initial begin : main_seq
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_register_overlap();
		test_kind_latch();
		test_random_traffic();
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
